>>> rtl/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table package
// Shared field widths, operation and status codes, entry and state types.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int MODE_W    = 3;
   localparam int POS_W     = 7;
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 3'd0,
      MODE_DELETE = 3'd1,
      MODE_GET    = 3'd2,
      MODE_FIND   = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_GET,
      ST_FIND
   } state_type;

   // One stored entry: key and opaque payload word.
   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
   } entry_type;

   // One result item.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [POS_W-1:0]        found_pos;
      logic signed [KEY_W-1:0] out_key;
      logic [PAYLOAD_W-1:0]    out_payload;
      logic [POS_W-1:0]        count;
      logic                    is_empty;
   } rsp_item_type;

endpackage

>>> rtl/plt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface plt_req_if;

   logic                             valid;
   logic                             ready;
   logic [plt_pkg::MODE_W-1:0]       mode;
   logic [plt_pkg::POS_W-1:0]        pos;
   logic signed [plt_pkg::KEY_W-1:0] key;
   logic [plt_pkg::PAYLOAD_W-1:0]    payload;

   modport source (output valid, output mode, output pos, output key, output payload,
                   input ready);
   modport sink   (input valid, input mode, input pos, input key, input payload,
                   output ready);

endinterface

>>> rtl/plt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface plt_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [plt_pkg::STATUS_W-1:0]     status;
   logic [plt_pkg::POS_W-1:0]        found_pos;
   logic signed [plt_pkg::KEY_W-1:0] out_key;
   logic [plt_pkg::PAYLOAD_W-1:0]    out_payload;
   logic [plt_pkg::POS_W-1:0]        count;
   logic                             is_empty;

   modport source (output valid, output status, output found_pos, output out_key,
                   output out_payload, output count, output is_empty, input ready);
   modport sink   (input valid, input status, input found_pos, input out_key,
                   input out_payload, input count, input is_empty, output ready);

endinterface

>>> rtl/positional_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table
// Ordered key/payload list with insert, delete, get, find and clear requests.
// ----------------------------------------------------------------------------
// The list lives in one single-port-write, one-port-read memory of CAPACITY
// entries (key and payload side by side) with a registered read, plus a count
// register. One request is worked on at a time and every request returns one
// item. Rejected requests, clear and unused modes are answered straight from
// the idle state; get reads the entry and answers from the get state. Insert
// and delete shift the tail of the list by one, each move being a read followed
// by a write on the single memory write port (moves overlap, so the loop
// streams one entry a cycle), then drain the last write and finish. Find
// does one memory read per entry scanned, stopping at the first match.
// The result register frees the response side: a new item is taken in the
// cycle its predecessor's result is taken. Stored entries need no reset; only
// entries at positions below the count are ever used.
// ----------------------------------------------------------------------------
module positional_list_table #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   plt_req_if.sink    req_bus,
   plt_rsp_if.source  rsp_bus
);

   import plt_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   // one spare bit so that count + 1 never wraps in the position checks
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] cnt_type;
   typedef logic [PW-1:0] cmp_type;

   // entry storage
   entry_type mem [CAPACITY];
   entry_type rdata_ff;
   logic      mem_we;
   addr_type  mem_waddr;
   entry_type mem_wdata;
   addr_type  mem_raddr;

   // control and held request
   state_type     state_ff, state_in;
   cnt_type       count_ff, count_in;
   mode_type      mode_ff, mode_in;
   entry_type     entry_ff, entry_in;
   addr_type      ins_addr_ff, ins_addr_in;
   addr_type      src_ff, src_in;
   addr_type      dst_ff, dst_in;
   cnt_type       remaining_ff, remaining_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic          req_ready;
   logic          req_take;
   mode_type      req_mode;
   cmp_type       pos_ext;
   cmp_type       cnt_ext;
   addr_type      pos_addr;
   logic          ins_bad;
   logic          acc_bad;
   logic          list_full;
   logic [AW:0]   found_idx;

   // Build a result item; count reflects the list after the operation.
   function automatic rsp_item_type make_rsp(status_type st, logic [POS_W-1:0] fpos,
                                             entry_type ent, cnt_type cnt);
      rsp_item_type r;
      r.status      = st;
      r.found_pos   = fpos;
      r.out_key     = ent.key;
      r.out_payload = ent.payload;
      r.count       = POS_W'(cnt);
      r.is_empty    = (cnt == '0);
      return r;
   endfunction

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Request decode; requests are taken in the idle state only, with the result register free or being taken.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_take  = req_ready && req_bus.valid;
   assign req_mode  = mode_type'(req_bus.mode);
   assign pos_ext   = cmp_type'(req_bus.pos);
   assign cnt_ext   = cmp_type'(count_ff);
   assign pos_addr  = addr_type'(req_bus.pos - 7'd1);
   assign ins_bad   = (req_bus.pos == '0) || (pos_ext > cnt_ext + cmp_type'(1));
   assign acc_bad   = (req_bus.pos == '0) || (pos_ext > cnt_ext);
   assign list_full = (count_ff == cnt_type'(CAPACITY));
   assign found_idx = {1'b0, dst_ff} + {{AW{1'b0}}, 1'b1};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      entry_in     = entry_ff;
      ins_addr_in  = ins_addr_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      remaining_in = remaining_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = dst_ff;
      mem_wdata    = rdata_ff;
      mem_raddr    = src_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // point the read port at the requested entry for a get
            mem_raddr = pos_addr;
            if (req_take) begin
               mode_in           = req_mode;
               entry_in.key      = req_bus.key;
               entry_in.payload  = req_bus.payload;
               ins_addr_in       = pos_addr;
               pend_in           = 1'b0;
               unique case (req_mode)
                  MODE_INSERT: begin
                     if (ins_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(STATUS_RANGE, '0, '0, count_ff);
                     end else if (list_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(STATUS_FULL, '0, '0, count_ff);
                     end else begin
                        // move entries pos-1 .. count-1 up by one, top first
                        remaining_in = cnt_type'(cnt_ext - pos_ext + cmp_type'(1));
                        src_in       = addr_type'(count_ff - cnt_type'(1));
                        state_in     = ST_MOVE;
                     end
                  end
                  MODE_DELETE: begin
                     if (acc_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(STATUS_RANGE, '0, '0, count_ff);
                     end else begin
                        // move entries pos .. count-1 down by one, bottom first
                        remaining_in = cnt_type'(cnt_ext - pos_ext);
                        src_in       = addr_type'(req_bus.pos);
                        state_in     = ST_MOVE;
                     end
                  end
                  MODE_GET: begin
                     if (acc_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = make_rsp(STATUS_RANGE, '0, '0, count_ff);
                     end else begin
                        state_in = ST_GET;
                     end
                  end
                  MODE_FIND: begin
                     remaining_in = count_ff;
                     src_in       = '0;
                     state_in     = ST_FIND;
                  end
                  MODE_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(STATUS_OK, '0, '0, '0);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(STATUS_OK, '0, '0, count_ff);
                  end
               endcase
            end
         end

         ST_MOVE: begin
            // issue the next source read; its data lands in the next cycle
            if (remaining_ff != '0) begin
               remaining_in = remaining_ff - cnt_type'(1);
               pend_in      = 1'b1;
               if (mode_ff == MODE_INSERT) begin
                  src_in = src_ff - addr_type'(1);
                  dst_in = src_ff + addr_type'(1);
               end else begin
                  src_in = src_ff + addr_type'(1);
                  dst_in = src_ff - addr_type'(1);
               end
            end else begin
               pend_in = 1'b0;
            end
            // write back the entry read last cycle
            if (pend_ff) begin
               mem_we = 1'b1;
            end else if (remaining_ff == '0) begin
               if (mode_ff == MODE_INSERT) begin
                  mem_we    = 1'b1;
                  mem_waddr = ins_addr_ff;
                  mem_wdata = entry_ff;
                  count_in  = count_ff + cnt_type'(1);
               end else begin
                  count_in  = count_ff - cnt_type'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, '0, '0, count_in);
               state_in     = ST_IDLE;
            end
         end

         ST_GET: begin
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(STATUS_OK, '0, rdata_ff, count_ff);
            state_in     = ST_IDLE;
         end

         ST_FIND: begin
            if (remaining_ff != '0) begin
               remaining_in = remaining_ff - cnt_type'(1);
               pend_in      = 1'b1;
               src_in       = src_ff + addr_type'(1);
               dst_in       = src_ff;
            end else begin
               pend_in = 1'b0;
            end
            // stop at the first match; otherwise drain the scan
            if (pend_ff && (rdata_ff.key == entry_ff.key)) begin
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, POS_W'(found_idx), '0, count_ff);
               state_in     = ST_IDLE;
            end else if (!pend_ff && (remaining_ff == '0)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(STATUS_OK, '0, '0, count_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers hold without reset
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      entry_ff     <= entry_in;
      ins_addr_ff  <= ins_addr_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      remaining_ff <= remaining_in;
      rsp_ff       <= rsp_in;
   end

   // drive the channels
   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.found_pos   = rsp_ff.found_pos;
   assign rsp_bus.out_key     = rsp_ff.out_key;
   assign rsp_bus.out_payload = rsp_ff.out_payload;
   assign rsp_bus.count       = rsp_ff.count;
   assign rsp_bus.is_empty    = rsp_ff.is_empty;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("entry count above capacity");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("memory written while idle");

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a request is in progress");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && pend_ff) |-> (int'(dst_ff) < CAPACITY))
      else $error("shift write outside the list storage");

endmodule

>>> tb/tb_positional_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table testbench
// Sends insert, delete, get, find, clear and unused-mode requests through the
// request channel and predicts every result with a mirror of the list kept
// in the bench. Each result item is compared field by field with the oldest
// prediction. Directed edge cases come first, then a full-list pass, then
// random traffic in four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_positional_list_table;

   import plt_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int MODE_LAST   = (1 << MODE_W) - 1;
   localparam int POS_LAST    = (1 << POS_W) - 1;
   localparam int DRAIN_TAIL  = CAPACITY + 8;    // longest shift or scan, plus margin
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 40;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   logic clock;
   logic reset;

   plt_req_if req_bus ();
   plt_rsp_if rsp_bus ();

   positional_list_table #(
      .CAPACITY (CAPACITY)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Mirror of the list: keys and payloads at 0-based slots, and its length.
   logic signed [KEY_W-1:0]  list_keys [CAPACITY];
   logic [PAYLOAD_W-1:0]     list_payloads [CAPACITY];
   int                       list_len;

   // Predicted results, oldest first.
   rsp_item_type expected_rsp [$];

   int send_idle_pct;
   int rsp_stall_pct;
   int cycle_count;
   int mismatch_count;
   int sent_count;
   int checked_count;
   int range_rejects;
   int full_rejects;
   int find_hits;
   int max_len_seen;

   // 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: no correct run comes near this many cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rsp.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Apply one request to the mirror and return the result it must produce.
   function automatic rsp_item_type table_apply(input logic [MODE_W-1:0] op,
                                                input logic [POS_W-1:0] at,
                                                input logic signed [KEY_W-1:0] k,
                                                input logic [PAYLOAD_W-1:0] data);
      rsp_item_type res;
      int           p;
      res        = '0;
      p          = int'(at);
      res.status = STATUS_OK;
      case (op)
         MODE_INSERT: begin
            // position is checked before fullness
            if (p < 1 || p > list_len + 1) begin
               res.status = STATUS_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               for (int i = list_len; i >= p; i--) begin
                  list_keys[i]     = list_keys[i-1];
                  list_payloads[i] = list_payloads[i-1];
               end
               list_keys[p-1]     = k;
               list_payloads[p-1] = data;
               list_len++;
            end
         end
         MODE_DELETE: begin
            if (p < 1 || p > list_len) begin
               res.status = STATUS_RANGE;
            end else begin
               for (int i = p; i < list_len; i++) begin
                  list_keys[i-1]     = list_keys[i];
                  list_payloads[i-1] = list_payloads[i];
               end
               list_len--;
            end
         end
         MODE_GET: begin
            if (p < 1 || p > list_len) begin
               res.status = STATUS_RANGE;
            end else begin
               res.out_key     = list_keys[p-1];
               res.out_payload = list_payloads[p-1];
            end
         end
         MODE_FIND: begin
            // first match wins
            for (int i = list_len - 1; i >= 0; i--) begin
               if (list_keys[i] == k) res.found_pos = POS_W'(i + 1);
            end
            if (res.found_pos != '0) find_hits++;
         end
         MODE_CLEAR: begin
            list_len = 0;
         end
         default: begin
            // unused modes change nothing
         end
      endcase
      if (res.status == STATUS_RANGE) range_rejects++;
      if (res.status == STATUS_FULL) full_rejects++;
      if (list_len > max_len_seen) max_len_seen = list_len;
      res.count    = POS_W'(list_len);
      res.is_empty = (list_len == 0);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_REPORTS) begin
         $display("tb: mismatch at result %0d (cycle %0d): %s got %0h expected %0h",
                  checked_count, cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   // Drive the receiver's ready at random and check every accepted result.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result with no request pending", '0, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
            if (rsp_bus.found_pos !== want.found_pos)
               report_mismatch("found_pos", 64'(rsp_bus.found_pos), 64'(want.found_pos));
            if (rsp_bus.out_key !== want.out_key)
               report_mismatch("out_key", 64'(unsigned'(rsp_bus.out_key)),
                               64'(unsigned'(want.out_key)));
            if (rsp_bus.out_payload !== want.out_payload)
               report_mismatch("out_payload", rsp_bus.out_payload, want.out_payload);
            if (rsp_bus.count !== want.count)
               report_mismatch("count", 64'(rsp_bus.count), 64'(want.count));
            if (rsp_bus.is_empty !== want.is_empty)
               report_mismatch("is_empty", 64'(rsp_bus.is_empty), 64'(want.is_empty));
         end
         checked_count++;
      end
   end

   // Send one request item. Entered and left at a rising edge; valid stays
   // high on return so that a following item can go out back to back.
   task automatic send_item(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] at,
                            input logic signed [KEY_W-1:0] k,
                            input logic [PAYLOAD_W-1:0] data);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         // mostly short gaps, now and then one long enough to span a shift
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= op;
      req_bus.pos     <= at;
      req_bus.key     <= k;
      req_bus.payload <= data;
      do @(posedge clock); while (!req_bus.ready);
      expected_rsp.push_back(table_apply(op, at, k, data));
      sent_count++;
   endtask

   // Hold the sender off until every predicted result has come back, then
   // let the block settle for the given number of cycles.
   task automatic wait_for_results(input int tail);
      req_bus.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Field extremes, every operation and every position rejection on a short list.
   task automatic test_directed_edges();
      send_idle_pct = 26;
      rsp_stall_pct = 26;
      // empty list: get, delete and bad insert positions are rejected
      send_item(MODE_GET,    1, '0, '0);
      send_item(MODE_DELETE, 1, '0, '0);
      send_item(MODE_FIND,   0, KEY_MIN, '0);
      send_item(MODE_INSERT, 0, KEY_MAX, '1);
      send_item(MODE_INSERT, 2, KEY_MAX, '1);
      // build [KEY_MAX, KEY_MIN, KEY_MIN, 0]: first, front, end, middle
      send_item(MODE_INSERT, 1, KEY_MIN, '1);
      send_item(MODE_INSERT, 1, KEY_MAX, '0);
      send_item(MODE_INSERT, 3, '0, {(PAYLOAD_W/2){2'b01}});
      send_item(MODE_INSERT, 2, KEY_MIN, {(PAYLOAD_W/2){2'b10}});
      // duplicate key: the first match is reported
      send_item(MODE_FIND, POS_W'(POS_LAST), KEY_MIN, '1);
      for (int i = 1; i <= 4; i++) send_item(MODE_GET, POS_W'(i), '1, '1);
      send_item(MODE_GET, 5, '0, '0);
      send_item(MODE_GET, 0, '0, '0);
      send_item(MODE_GET, POS_W'(POS_LAST), '0, '0);
      send_item(MODE_DELETE, 2, '0, '0);
      send_item(MODE_DELETE, 4, '0, '0);
      send_item(MODE_DELETE, 0, '0, '0);
      send_item(MODE_FIND, 1, 32'sd1, '0);
      send_item(MODE_INSERT, 5, '0, '0);
      for (int m = MODE_CLEAR + 1; m <= MODE_LAST; m++)
         send_item(MODE_W'(m), POS_W'($urandom_range(0, POS_LAST)), $urandom,
                   {$urandom, $urandom});
      send_item(MODE_CLEAR, POS_W'(POS_LAST), '1, '1);
      wait_for_results(DRAIN_TAIL);
   endtask

   // Fill to capacity, then probe the full and just-past-full positions.
   task automatic test_full_list();
      send_idle_pct = 0;
      rsp_stall_pct = 52;
      while (list_len < CAPACITY)
         send_item(MODE_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom,
                   {$urandom, $urandom});
      send_item(MODE_INSERT, 1, KEY_MIN, '1);
      send_item(MODE_INSERT, POS_W'(CAPACITY + 1), KEY_MIN, '1);
      send_item(MODE_INSERT, POS_W'(CAPACITY + 2), KEY_MIN, '1);
      send_item(MODE_INSERT, POS_W'(POS_LAST), KEY_MIN, '1);
      send_item(MODE_GET, POS_W'(CAPACITY), '0, '0);
      send_item(MODE_GET, POS_W'(CAPACITY + 1), '0, '0);
      send_item(MODE_FIND, 0, list_keys[CAPACITY-1], '0);
      send_item(MODE_DELETE, POS_W'(CAPACITY), '0, '0);
      send_item(MODE_INSERT, POS_W'(CAPACITY), KEY_MAX, '0);
      send_item(MODE_DELETE, 1, '0, '0);
      send_item(MODE_CLEAR, 0, '0, '0);
      wait_for_results(DRAIN_TAIL);
   endtask

   // Random requests. Alternate growing and shrinking stretches so the list
   // swings between empty and full; most positions and find keys are valid.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n);
      int                       r;
      int                       p;
      int                       ins_w;
      int                       del_w;
      bit                       growing;
      logic [MODE_W-1:0]        op;
      logic signed [KEY_W-1:0]  k;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      growing       = $urandom_range(0, 1);
      for (int j = 0; j < n; j++) begin
         if (j % 80 == 79) growing = !growing;
         ins_w = growing ? 55 : 20;
         del_w = growing ? 10 : 45;
         r = $urandom_range(0, 99);
         if (r < ins_w) op = MODE_INSERT;
         else if (r < ins_w + del_w) op = MODE_DELETE;
         else if (r < 80) op = MODE_GET;
         else if (r < 96) op = MODE_FIND;
         else if (r < 97) op = MODE_CLEAR;
         else op = MODE_W'($urandom_range(MODE_CLEAR + 1, MODE_LAST));

         if ($urandom_range(0, 9) == 0) p = $urandom_range(0, POS_LAST);
         else if (op == MODE_INSERT) p = $urandom_range(1, list_len + 1);
         else if (list_len > 0) p = $urandom_range(1, list_len);
         else p = $urandom_range(0, POS_LAST);

         r = $urandom_range(0, 99);
         if (op == MODE_FIND && list_len > 0 && r < 60) k = list_keys[$urandom_range(0, list_len - 1)];
         else if (r < 70) k = $urandom;
         else if (r < 95) k = $urandom_range(0, 15);   // small pool: duplicates
         else k = (r[0]) ? KEY_MIN : KEY_MAX;

         send_item(op, POS_W'(p), k, {$urandom, $urandom});
      end
      wait_for_results(DRAIN_TAIL);
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_INSERT;
      req_bus.pos     = '0;
      req_bus.key     = '0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      list_len        = 0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      cycle_count     = 0;
      mismatch_count  = 0;
      sent_count      = 0;
      checked_count   = 0;
      range_rejects   = 0;
      full_rejects    = 0;
      find_hits       = 0;
      max_len_seen    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_full_list();
      test_random_traffic(0, 0, 175);
      test_random_traffic(52, 0, 175);
      test_random_traffic(0, 52, 175);
      test_random_traffic(26, 26, 175);

      wait_for_results(DRAIN_TAIL);
      if (expected_rsp.size() != 0)
         report_mismatch("results never returned", 64'(expected_rsp.size()), '0);

      $display("tb: %0d requests sent, %0d results checked, %0d mismatches",
               sent_count, checked_count, mismatch_count);
      $display("tb: %0d position rejects, %0d full rejects, %0d find hits, longest list %0d",
               range_rejects, full_rejects, find_hits, max_len_seen);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
